### rtl/core/vsdc_pkg.sv
// Package with shared constants, types and codes of the valve settle delay calculator.
package vsdc_pkg;
    localparam int VALVES_DEF = 8;
    localparam logic [15:0] MARGIN_MS = 16'd12;
    localparam logic [15:0] CEILING_MS = 16'd400;
    localparam logic [31:0] MILLION = 32'd1000000;
    localparam logic [15:0] THOUSAND = 16'd1000;
    localparam logic [1:0] ACT_OFF = 2'd0;
    localparam logic [1:0] ACT_SERVO = 2'd1;
    localparam logic [1:0] ACT_SOLENOID = 2'd2;
    localparam logic [2:0] REG_SYNC = 3'd0;
    localparam logic [2:0] REG_FOLLOW = 3'd1;
    localparam logic [2:0] REG_ONLY = 3'd2;
    localparam logic [2:0] REG_TRIM = 3'd3;
    localparam logic [2:0] REG_MAX = 3'd4;
    localparam logic [2:0] REG_COUNT = 3'd5;

    // Configuration seen by the note logic.
    typedef struct packed {
        logic        sync_enabled;
        logic        follow_notes;
        logic        only_on_change;
        logic [15:0] trim_ms;
        logic [15:0] max_delay_ms;
        logic [3:0]  valve_count;
    } t_cfg;
endpackage

### rtl/core/vsdc_if.sv
// Valid/ready channel interfaces for input and result items.
interface vsdc_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [2:0]  valve_index;
    logic [1:0]  actuator_type;
    logic [15:0] measured_settle_ms;
    logic [7:0]  pressed_angle;
    logic [7:0]  released_angle;
    logic [15:0] servo_speed;
    logic [15:0] servo_accel;
    logic [15:0] pull_in_ms;
    logic [7:0]  from_mask;
    logic [7:0]  to_mask;
    modport source (output valid, mode, valve_index, actuator_type, measured_settle_ms,
        pressed_angle, released_angle, servo_speed, servo_accel, pull_in_ms, from_mask,
        to_mask, input ready);
    modport sink (input valid, mode, valve_index, actuator_type, measured_settle_ms,
        pressed_angle, released_angle, servo_speed, servo_accel, pull_in_ms, from_mask,
        to_mask, output ready);
endinterface

interface vsdc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] delay_ms;
    modport source (output valid, delay_ms, input ready);
    modport sink (input valid, delay_ms, output ready);
endinterface

### rtl/core/vsdc_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module vsdc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [31:0] r_q;
    logic [32:0] r_r;
    logic [31:0] r_d;
    logic        r_done;
    logic [32:0] n_shift;

    assign n_shift = {r_r[31:0], r_q[31]};

    // Shift in one numerator bit and try a subtract.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd32;
                r_q <= i_num;
                r_r <= '0;
                r_d <= i_den;
            end else if (r_busy) begin
                if (n_shift >= {1'b0, r_d}) begin
                    r_r <= n_shift - {1'b0, r_d};
                    r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_r <= n_shift;
                    r_q <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem = r_r[31:0];
endmodule

### rtl/core/vsdc_settle.sv
// Settle time sequencer for load items: runs divides and an iterative square root in sequence.
module vsdc_settle (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_type,
    input  logic [15:0] i_measured,
    input  logic [7:0]  i_pressed,
    input  logic [7:0]  i_released,
    input  logic [15:0] i_speed,
    input  logic [15:0] i_accel,
    input  logic [15:0] i_pull_in,
    output logic        o_done,
    output logic [15:0] o_settle
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIV_RV, S_DIV_DV, S_DIV_VA, S_DIV_MA, S_MUL, S_DIV_RD,
        S_SQRT, S_FINISH
    } t_state;

    t_state      r_state;
    logic [7:0]  r_d;
    logic [15:0] r_v;
    logic [15:0] r_a;
    logic [31:0] r_t1;
    logic [31:0] r_t2;
    logic [31:0] r_x;
    logic [31:0] r_res;
    logic [31:0] r_bit;
    logic [31:0] r_total;
    logic        r_done;
    logic [15:0] r_settle;
    logic        r_dstart;
    logic [31:0] r_num;
    logic [31:0] r_den;
    logic        w_ddone;
    logic [31:0] w_quot;
    logic [31:0] w_rem;

    vsdc_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_num(r_num),
        .i_den(r_den), .o_done(w_ddone), .o_quot(w_quot), .o_rem(w_rem)
    );

    // Profile sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_dstart <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_d <= (i_pressed > i_released) ? i_pressed - i_released
                                                        : i_released - i_pressed;
                        r_v <= i_speed;
                        r_a <= i_accel;
                        r_total <= {16'd0, i_pull_in} + {16'd0, vsdc_pkg::MARGIN_MS};
                        if (i_measured != 16'd0) begin
                            r_settle <= i_measured;
                            r_done <= 1'b1;
                        end else if (i_type == vsdc_pkg::ACT_SOLENOID) begin
                            r_state <= S_FINISH;
                        end else if (i_type == vsdc_pkg::ACT_SERVO) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_settle <= 16'd0;
                            r_done <= 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_v == 16'd0) begin
                        r_settle <= vsdc_pkg::CEILING_MS;
                        r_done <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_d == 8'd0) begin
                        r_total <= {16'd0, vsdc_pkg::MARGIN_MS};
                        r_state <= S_FINISH;
                    end else begin
                        // d*1000/v first; needed by the accel-free and cruise cases.
                        r_num <= 32'(r_d) * 32'(vsdc_pkg::THOUSAND);
                        r_den <= {16'd0, r_v};
                        r_dstart <= 1'b1;
                        r_state <= S_DIV_DV;
                    end
                end
                S_DIV_DV: begin
                    if (w_ddone) begin
                        r_t1 <= w_quot;
                        if (r_a == 16'd0) begin
                            r_total <= w_quot + 32'(vsdc_pkg::MARGIN_MS);
                            r_state <= S_FINISH;
                        end else begin
                            r_num <= 32'(r_v) * 32'(r_v);
                            r_den <= {16'd0, r_a};
                            r_dstart <= 1'b1;
                            r_state <= S_DIV_RV;
                        end
                    end
                end
                S_DIV_RV: begin
                    if (w_ddone) begin
                        if (32'(r_d) <= w_quot) begin
                            r_num <= vsdc_pkg::MILLION;
                            r_state <= S_DIV_MA;
                        end else begin
                            r_num <= 32'(r_v) * 32'(vsdc_pkg::THOUSAND);
                            r_state <= S_DIV_VA;
                        end
                        r_den <= {16'd0, r_a};
                        r_dstart <= 1'b1;
                    end
                end
                S_DIV_VA: begin
                    if (w_ddone) begin
                        r_total <= r_t1 + w_quot + 32'(vsdc_pkg::MARGIN_MS);
                        r_state <= S_FINISH;
                    end
                end
                S_DIV_MA: begin
                    if (w_ddone) begin
                        r_t1 <= w_quot;
                        r_t2 <= w_rem;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_t1 <= r_t1 * 32'(r_d);
                    r_num <= r_t2 * 32'(r_d);
                    r_den <= {16'd0, r_a};
                    r_dstart <= 1'b1;
                    r_state <= S_DIV_RD;
                end
                S_DIV_RD: begin
                    if (w_ddone) begin
                        r_x <= r_t1 + w_quot;
                        r_res <= '0;
                        r_bit <= 32'h4000_0000;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // One result bit per cycle; leading zero pairs just shift.
                    if (r_bit == 32'd0) begin
                        r_total <= {r_res[30:0], 1'b0} + 32'(vsdc_pkg::MARGIN_MS);
                        r_state <= S_FINISH;
                    end else begin
                        if (r_x >= r_res + r_bit) begin
                            r_x <= r_x - (r_res + r_bit);
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_FINISH: begin
                    r_settle <= (r_total > 32'(vsdc_pkg::CEILING_MS)) ? vsdc_pkg::CEILING_MS
                                                                      : r_total[15:0];
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_settle = r_settle;
endmodule

### rtl/core/valve_settle_delay_calculator.sv
// Top level: settle table memory, load and note sequencing, APB registers.
// Loads run through the settle sequencer; a servo profile takes up to four divides and a
// square root. A note scans the table, then trims and clamps its worst entry. One item at
// a time: the input is ready only while idle.
// A finished note waits while the output register still holds an untaken result.
// Synchronous active-low reset; the table is cleared by a pass over every entry after reset.
module valve_settle_delay_calculator #(
    parameter int VALVES = vsdc_pkg::VALVES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vsdc_in_if.sink     i_in,
    vsdc_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = (VALVES > 1) ? $clog2(VALVES) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_SCAN, S_SCAN_LAST, S_TRIM, S_OUT
    } t_state;

    t_state         r_state;
    vsdc_pkg::t_cfg r_cfg;
    logic [15:0]    r_mem [VALVES];
    logic [15:0]    r_rdata;
    logic [IW:0]    r_ptr;
    logic [IW-1:0]  r_widx;
    logic           r_wvalid;
    logic [7:0]     r_mask;
    logic [15:0]    r_worst;
    logic [15:0]    r_delay;
    logic           r_zero;
    logic [3:0]     r_n;
    logic           w_sdone;
    logic [15:0]    w_settle;
    logic           w_start;
    logic           w_we;
    logic [IW-1:0]  w_waddr;
    logic [15:0]    w_wdata;
    logic [IW-1:0]  w_raddr;
    logic [2:0]     w_reg;
    logic           w_change;
    logic [IW:0]    r_rptr;
    logic signed [17:0] w_sum;

    assign w_reg = paddr[4:2];
    assign pready = 1'b1;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_start = i_in.valid && i_in.ready && !i_in.mode;
    assign w_change = i_in.from_mask != i_in.to_mask;

    vsdc_settle u_settle (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_type(i_in.actuator_type),
        .i_measured(i_in.measured_settle_ms), .i_pressed(i_in.pressed_angle),
        .i_released(i_in.released_angle), .i_speed(i_in.servo_speed),
        .i_accel(i_in.servo_accel), .i_pull_in(i_in.pull_in_ms),
        .o_done(w_sdone), .o_settle(w_settle)
    );

    // Register writes and reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{1'b0, 1'b0, 1'b1, 16'd0, 16'd400, 4'd0};
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                vsdc_pkg::REG_SYNC:   r_cfg.sync_enabled <= pwdata[0];
                vsdc_pkg::REG_FOLLOW: r_cfg.follow_notes <= pwdata[0];
                vsdc_pkg::REG_ONLY:   r_cfg.only_on_change <= pwdata[0];
                vsdc_pkg::REG_TRIM:   r_cfg.trim_ms <= pwdata[15:0];
                vsdc_pkg::REG_MAX:    r_cfg.max_delay_ms <= pwdata[15:0];
                vsdc_pkg::REG_COUNT:  r_cfg.valve_count <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            vsdc_pkg::REG_SYNC:   prdata = {31'd0, r_cfg.sync_enabled};
            vsdc_pkg::REG_FOLLOW: prdata = {31'd0, r_cfg.follow_notes};
            vsdc_pkg::REG_ONLY:   prdata = {31'd0, r_cfg.only_on_change};
            vsdc_pkg::REG_TRIM:   prdata = {16'd0, r_cfg.trim_ms};
            vsdc_pkg::REG_MAX:    prdata = {16'd0, r_cfg.max_delay_ms};
            vsdc_pkg::REG_COUNT:  prdata = {28'd0, r_cfg.valve_count};
            default:              prdata = 32'd0;
        endcase
    end

    // Memory write port: clearing pass or settled load.
    assign w_we = (r_state == S_CLEAR) || (r_state == S_LOAD && w_sdone && r_wvalid);
    assign w_waddr = (r_state == S_CLEAR) ? r_ptr[IW-1:0] : r_widx;
    assign w_wdata = (r_state == S_CLEAR) ? 16'd0 : w_settle;
    assign w_raddr = r_ptr[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    assign w_sum = $signed({2'b00, r_worst}) + 18'(signed'(r_cfg.trim_ms));

    // Item sequencer; the scan reads one entry a cycle and folds the previous one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr <= '0;
            o_out.valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready && r_state != S_OUT) o_out.valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == (IW + 1)'(VALVES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    r_ptr <= '0;
                    r_rptr <= '0;
                    r_worst <= '0;
                    r_n <= (r_cfg.valve_count > 4'(VALVES)) ? 4'(VALVES) : r_cfg.valve_count;
                    r_mask <= w_change ? (i_in.from_mask ^ i_in.to_mask) : i_in.to_mask;
                    r_zero <= !r_cfg.sync_enabled || !r_cfg.follow_notes ||
                              (r_cfg.only_on_change && !w_change);
                    r_widx <= IW'(i_in.valve_index);
                    r_wvalid <= 32'(i_in.valve_index) < VALVES;
                    if (i_in.valid) begin
                        r_state <= i_in.mode ? S_SCAN : S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (w_sdone) r_state <= S_IDLE;
                end
                S_SCAN: begin
                    // Address r_ptr issued now; data of r_rptr arrives.
                    if (r_ptr != '0 && 4'(r_rptr) < r_n && r_mask[r_rptr[IW-1:0]] &&
                        r_rdata > r_worst) r_worst <= r_rdata;
                    r_rptr <= r_ptr;
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == (IW + 1)'(VALVES - 1)) r_state <= S_SCAN_LAST;
                end
                S_SCAN_LAST: begin
                    if (4'(r_rptr) < r_n && r_mask[r_rptr[IW-1:0]] && r_rdata > r_worst)
                        r_worst <= r_rdata;
                    r_state <= S_TRIM;
                end
                S_TRIM: begin
                    if (r_zero || r_worst == 16'd0 || w_sum < 18'sd0) r_delay <= 16'd0;
                    else if (w_sum > $signed({2'b00, r_cfg.max_delay_ms}))
                        r_delay <= r_cfg.max_delay_ms;
                    else r_delay <= w_sum[15:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hand over once the output register is free or being emptied.
                    if (!o_out.valid || o_out.ready) begin
                        o_out.delay_ms <= r_delay;
                        o_out.valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### sim/valve_settle_delay_calculator_tb.sv
// Self-checking testbench of the valve settle delay calculator with random stimulus.
`timescale 1ns / 100ps

module valve_settle_delay_calculator_tb;
    localparam int NVALVES = 8;

    // One input item as offered on the input channel.
    typedef struct packed {
        logic        mode;
        logic [2:0]  valve_index;
        logic [1:0]  actuator_type;
        logic [15:0] measured_settle_ms;
        logic [7:0]  pressed_angle;
        logic [7:0]  released_angle;
        logic [15:0] servo_speed;
        logic [15:0] servo_accel;
        logic [15:0] pull_in_ms;
        logic [7:0]  from_mask;
        logic [7:0]  to_mask;
    } t_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vsdc_in_if  in_ch ();
    vsdc_out_if out_ch ();

    valve_settle_delay_calculator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: settle table and register copies.
    logic [15:0] settle_ms_q [NVALVES];
    logic        cfg_sync;
    logic        cfg_follow;
    logic        cfg_only;
    logic [15:0] cfg_trim;
    logic [15:0] cfg_max;
    logic [3:0]  cfg_count;

    t_item       pending_items [$];
    logic [15:0] expected_delays [$];
    int          mismatches;
    int          notes_checked;
    int          loads_sent;
    bit          idle_enabled;
    bit          hold_off_active;

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic [31:0] isqrt(input logic [31:0] x_in);
        logic [31:0] x;
        logic [31:0] res;
        logic [31:0] b;
        x = x_in;
        res = 0;
        b = 32'h4000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Settle time stored for one load item.
    function automatic logic [15:0] settle_time(input t_item it);
        logic [31:0] d;
        logic [31:0] v;
        logic [31:0] a;
        logic [31:0] travel;
        logic [31:0] total;
        if (it.measured_settle_ms != 0) return it.measured_settle_ms;
        if (it.actuator_type == vsdc_pkg::ACT_SERVO) begin
            v = it.servo_speed;
            a = it.servo_accel;
            if (v == 0) return vsdc_pkg::CEILING_MS;
            d = (it.pressed_angle > it.released_angle) ?
                it.pressed_angle - it.released_angle : it.released_angle - it.pressed_angle;
            if (d == 0) travel = 0;
            else if (a == 0) travel = (d * 1000) / v;
            else if (d <= (v * v) / a)
                travel = 2 * isqrt((vsdc_pkg::MILLION / a) * d +
                                   ((vsdc_pkg::MILLION % a) * d) / a);
            else travel = (d * 1000) / v + (v * 1000) / a;
            total = travel + vsdc_pkg::MARGIN_MS;
        end else if (it.actuator_type == vsdc_pkg::ACT_SOLENOID) begin
            total = it.pull_in_ms + vsdc_pkg::MARGIN_MS;
        end else begin
            return 16'd0;
        end
        return (total > vsdc_pkg::CEILING_MS) ? vsdc_pkg::CEILING_MS : total[15:0];
    endfunction

    // Attack delay of one note item.
    function automatic logic [15:0] attack_delay(input t_item it);
        logic [7:0]  mask;
        logic [15:0] worst;
        int          n;
        int          total;
        if (!cfg_sync || !cfg_follow) return 16'd0;
        if (cfg_only && it.from_mask == it.to_mask) return 16'd0;
        mask = (it.from_mask != it.to_mask) ? (it.from_mask ^ it.to_mask) : it.to_mask;
        n = (cfg_count > NVALVES) ? NVALVES : cfg_count;
        worst = 0;
        for (int i = 0; i < n; i++)
            if (mask[i] && settle_ms_q[i] > worst) worst = settle_ms_q[i];
        if (worst == 0) return 16'd0;
        total = int'(worst) + int'($signed(cfg_trim));
        if (total < 0) total = 0;
        if (total > int'(cfg_max)) total = cfg_max;
        return total[15:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // Register write over APB: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            vsdc_pkg::REG_SYNC:   cfg_sync   = value[0];
            vsdc_pkg::REG_FOLLOW: cfg_follow = value[0];
            vsdc_pkg::REG_ONLY:   cfg_only   = value[0];
            vsdc_pkg::REG_TRIM:   cfg_trim   = value[15:0];
            vsdc_pkg::REG_MAX:    cfg_max    = value[15:0];
            vsdc_pkg::REG_COUNT:  cfg_count  = value[3:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic s, input logic f, input logic o,
                             input logic [15:0] t, input logic [15:0] m,
                             input logic [3:0] c);
        write_reg(vsdc_pkg::REG_SYNC, s);
        write_reg(vsdc_pkg::REG_FOLLOW, f);
        write_reg(vsdc_pkg::REG_ONLY, o);
        write_reg(vsdc_pkg::REG_TRIM, t);
        write_reg(vsdc_pkg::REG_MAX, m);
        write_reg(vsdc_pkg::REG_COUNT, c);
    endtask

    // Wait until all queued items are accepted and all results have come, then drain.
    task automatic settle_down();
        while (pending_items.size() != 0 || expected_delays.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    function automatic t_item random_load();
        t_item it;
        it = '0;
        it.mode          = 1'b0;
        it.valve_index   = $urandom_range(0, 7);
        it.actuator_type = $urandom_range(0, 3);
        it.measured_settle_ms = ($urandom_range(0, 3) == 0) ? $urandom : 16'd0;
        it.pressed_angle  = $urandom_range(0, 180);
        it.released_angle = $urandom_range(0, 180);
        case ($urandom_range(0, 3))
            0: it.servo_speed = $urandom;
            1: it.servo_speed = $urandom_range(0, 20);
            default: it.servo_speed = $urandom_range(30, 1000);
        endcase
        case ($urandom_range(0, 3))
            0: it.servo_accel = 16'd0;
            1: it.servo_accel = $urandom;
            default: it.servo_accel = $urandom_range(1, 5000);
        endcase
        it.pull_in_ms = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 500);
        it.from_mask  = $urandom;
        it.to_mask    = $urandom;
        return it;
    endfunction

    function automatic t_item random_note();
        t_item it;
        it = random_load();
        it.mode = 1'b1;
        if ($urandom_range(0, 4) == 0) it.to_mask = it.from_mask;
        return it;
    endfunction

    // Input driver: predicts each accepted item in order, then offers the head of the
    // queue, with random idle bursts.
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                if (!in_ch.mode) begin
                    settle_ms_q[in_ch.valve_index] <= settle_time(pending_items[0]);
                    loads_sent++;
                end else begin
                    expected_delays.push_back(attack_delay(pending_items[0]));
                end
                void'(pending_items.pop_front());
                send_gap = idle_enabled && $urandom_range(0, 5) == 0 ?
                    $urandom_range(1, 7) : 0;
            end
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                t_item nx;
                nx = pending_items[0];
                in_ch.valid              <= 1'b1;
                in_ch.mode               <= nx.mode;
                in_ch.valve_index        <= nx.valve_index;
                in_ch.actuator_type      <= nx.actuator_type;
                in_ch.measured_settle_ms <= nx.measured_settle_ms;
                in_ch.pressed_angle      <= nx.pressed_angle;
                in_ch.released_angle     <= nx.released_angle;
                in_ch.servo_speed        <= nx.servo_speed;
                in_ch.servo_accel        <= nx.servo_accel;
                in_ch.pull_in_ms         <= nx.pull_in_ms;
                in_ch.from_mask          <= nx.from_mask;
                in_ch.to_mask            <= nx.to_mask;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stalls; a requested hold-off is counted here.
    int recv_gap;
    int hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_delays.size() == 0) begin
                    report_mismatch("unexpected result delay_ms", out_ch.delay_ms, 16'd0);
                end else begin
                    if (out_ch.delay_ms !== expected_delays[0])
                        report_mismatch("delay_ms", out_ch.delay_ms, expected_delays[0]);
                    void'(expected_delays.pop_front());
                end
                notes_checked++;
            end
            if (hold_off_active) begin
                hold_left = 2000;
                hold_off_active = 1'b0;
            end
            if (recv_gap == 0 && idle_enabled && $urandom_range(0, 7) == 0)
                recv_gap = $urandom_range(1, 7);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus.
    initial begin
        t_item it;
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.valve_index = '0;
        in_ch.actuator_type = '0;
        in_ch.measured_settle_ms = '0;
        in_ch.pressed_angle = '0;
        in_ch.released_angle = '0;
        in_ch.servo_speed = '0;
        in_ch.servo_accel = '0;
        in_ch.pull_in_ms = '0;
        in_ch.from_mask = '0;
        in_ch.to_mask = '0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        notes_checked = 0;
        loads_sent = 0;
        idle_enabled = 1'b1;
        hold_off_active = 1'b0;
        for (int i = 0; i < NVALVES; i++) settle_ms_q[i] = '0;
        cfg_sync = 1'b0;
        cfg_follow = 1'b0;
        cfg_only = 1'b1;
        cfg_trim = '0;
        cfg_max = 16'd400;
        cfg_count = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (20) @(posedge i_clk);

        // A note under reset settings is gated off.
        it = '0;
        it.mode = 1'b1;
        it.from_mask = 8'h01;
        it.to_mask = 8'h02;
        pending_items.push_back(it);
        settle_down();

        // Directed loads: measured, servo profiles, solenoid, unused type.
        write_all(1'b1, 1'b1, 1'b1, 16'd0, 16'hFFFF, 4'd8);
        it = '0;
        it.measured_settle_ms = 16'hFFFF;
        pending_items.push_back(it);
        it = '0; it.valve_index = 1; it.actuator_type = vsdc_pkg::ACT_SERVO;
        it.pressed_angle = 180; it.released_angle = 0; it.servo_speed = 60;
        it.servo_accel = 0;
        pending_items.push_back(it);
        it.valve_index = 2; it.servo_speed = 16'hFFFF; it.servo_accel = 16'hFFFF;
        pending_items.push_back(it);
        it.valve_index = 3; it.servo_speed = 300; it.servo_accel = 5000;
        it.pressed_angle = 90; it.released_angle = 10;
        pending_items.push_back(it);
        it.valve_index = 4; it.servo_speed = 0;
        pending_items.push_back(it);
        it = '0; it.valve_index = 5; it.actuator_type = vsdc_pkg::ACT_SERVO;
        it.pressed_angle = 45; it.released_angle = 45; it.servo_speed = 100;
        pending_items.push_back(it);
        it = '0; it.valve_index = 6; it.actuator_type = vsdc_pkg::ACT_SOLENOID;
        it.pull_in_ms = 16'hFFFF;
        pending_items.push_back(it);
        it = '0; it.valve_index = 7; it.actuator_type = 2'd3; it.pull_in_ms = 50;
        pending_items.push_back(it);
        // Notes over all valves, unchanged fingering, and all-ones masks.
        it = '0; it.mode = 1'b1; it.from_mask = 8'h00; it.to_mask = 8'hFF;
        pending_items.push_back(it);
        it.from_mask = 8'hFF; it.to_mask = 8'hFF;
        pending_items.push_back(it);
        it.from_mask = 8'h80; it.to_mask = 8'h40;
        pending_items.push_back(it);
        settle_down();
        // Always wait policy, negative trim to zero, small clamp, count beyond table.
        write_all(1'b1, 1'b1, 1'b0, 16'h8000, 16'd0, 4'd15);
        it = '0; it.mode = 1'b1; it.from_mask = 8'h0F; it.to_mask = 8'h0F;
        pending_items.push_back(it);
        settle_down();
        write_all(1'b1, 1'b1, 1'b0, 16'h7FFF, 16'd100, 4'd3);
        pending_items.push_back(it);
        it.from_mask = 8'h00; it.to_mask = 8'hF8;
        pending_items.push_back(it);
        settle_down();
        write_all(1'b1, 1'b0, 1'b0, 16'd5, 16'd400, 4'd8);
        pending_items.push_back(it);
        settle_down();

        // Random phases across settings; a long receiver stall in the first.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) idle_enabled = 1'b0;
            write_all(ph != 2, ph != 3, $urandom_range(0, 1),
                      (ph == 4) ? 16'h8000 : (ph == 5) ? 16'h7FFF : 16'($urandom_range(0, 200)
                      - 100), (ph == 6) ? 16'hFFFF : 16'($urandom_range(0, 600)),
                      $urandom_range(0, 15));
            for (int k = 0; k < 250; k++)
                pending_items.push_back(($urandom_range(0, 2) == 0) ? random_load() :
                                        random_note());
            if (ph == 0) hold_off_active = 1'b1;
            settle_down();
        end

        $display("Covered %0d load items and %0d note results across eight settings,",
                 loads_sent, notes_checked);
        $display("including a long output stall and extreme trim and clamp values.");
        if (mismatches == 0) begin
            $display("[valve_settle_delay_calculator] OK");
        end else begin
            $display("[valve_settle_delay_calculator] ERROR");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #3000000;
        $display("[valve_settle_delay_calculator] ERROR");
        $finish;
    end
endmodule
